@@ src/sacp_pkg.sv @@
`default_nettype none
package sacp_pkg;

    localparam int SENSORS = 32;
    localparam int IDX_W   = $clog2(SENSORS);
    localparam int CNT_W   = IDX_W + 1;
    localparam int NORM_W  = 18;
    localparam int TOT_W   = NORM_W + IDX_W;
    localparam int SUM_W   = 16 + NORM_W + 1 + IDX_W;
    localparam int NUM_W   = SUM_W + 1;
    localparam int MIN_ACTIVE = 4;

    localparam logic [2:0] CFG_COG_ABS = 3'd0;
    localparam logic [2:0] CFG_COG_REL = 3'd1;
    localparam logic [2:0] CFG_SEL_ABS = 3'd2;
    localparam logic [2:0] CFG_SEL_REL = 3'd3;
    localparam logic [2:0] CFG_RADIUS  = 3'd4;
    localparam logic [2:0] CFG_ESCALE  = 3'd5;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FEW      = 2'd1;
    localparam logic [1:0] ST_NOWEIGHT = 2'd2;

    localparam logic [15:0] UNITY_GAIN = 16'd16384;

    typedef struct packed {
        logic               command;
        logic [4:0]         sensor_index;
        logic signed [15:0] pos_x;
        logic signed [15:0] pos_y;
        logic [15:0]        gain_recip;
        logic               enabled;
        logic [15:0]        amplitude;
        logic               saturated;
        logic               last;
    } t_in_item;

    typedef struct packed {
        logic [1:0]         status;
        logic signed [15:0] guess_x;
        logic signed [15:0] guess_y;
        logic [31:0]        energy;
        logic [5:0]         active_count;
        logic [31:0]        active_mask;
    } t_out_item;

    typedef struct packed {
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        gain;
        logic               en;
        logic [NORM_W-1:0]  norm;
        logic               sat;
    } t_sensor_rd;

    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   addr;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [15:0]        gain;
        logic               en;
    } t_tbl_wr;

    typedef struct packed {
        logic               we;
        logic [IDX_W-1:0]   addr;
        logic [NORM_W-1:0]  norm;
        logic               sat;
    } t_amp_wr;

endpackage
`default_nettype wire

@@ src/sensor_array_centroid_prefit.sv @@
// Sensor-array centre-of-gravity prefit.
// Input channel (i_in_valid / o_in_stall, i_in_item): command 0 loads a
// sensor table entry, command 1 delivers one sample of an event. An item
// is taken when valid is high and stall is low.
// Output channel (o_out_valid / i_out_stall, o_out_item): one result per
// sample marked last.
// Config channel (i_cfg_valid / o_cfg_ready): always ready; write only while
// the block is idle.
// Steps: a load writes the table as it is taken; a sample does a table read,
// then gain multiply and write of the amplitude memory. A last sample adds the
// event finish: three sweeps of the 32-entry amplitude/table memories, a
// cutoff step, a divider start step and a 41-step serial divider, after
// which the result is registered; when no sensor has weight the divider and
// the third sweep are skipped.
// The result register holds the item while i_out_stall is high; loads and
// samples keep flowing meanwhile, only the next event finish waits for it.
// Reset: config returns to defaults, table gains to unity, enables to one,
// saturation flags to zero; no result is pending.
`default_nettype none
module sensor_array_centroid_prefit (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire sacp_pkg::t_in_item  i_in_item,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output sacp_pkg::t_out_item      o_out_item,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic [2:0]          i_cfg_index,
    input  wire logic [17:0]         i_cfg_data
);
    import sacp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_SMP, S_P1, S_CUT, S_P2, S_DIVST, S_DIV, S_P3, S_OUT
    } t_state;

    t_state r_state;

    logic [17:0] r_cog_abs, r_sel_abs;
    logic [15:0] r_cog_rel, r_sel_rel, r_radius, r_escale;

    logic [IDX_W-1:0]   r_sidx;
    logic [15:0]        r_amp;
    logic               r_sat, r_last;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_iss;
    logic [IDX_W-1:0]   r_iss_idx;
    logic [NORM_W-1:0]  r_peak;
    logic [TOT_W-1:0]   r_total;
    logic [NORM_W-1:0]  r_cut_cog, r_cut_sel;
    logic signed [SUM_W-1:0] r_sx, r_sy;
    logic [TOT_W-1:0]   r_sw;
    logic               r_weight;
    logic signed [15:0] r_gx, r_gy;
    logic               r_s3v, r_s3ok;
    logic [IDX_W-1:0]   r_s3idx;
    logic [33:0]        r_dx2, r_dy2;
    logic [5:0]         r_count;
    logic [31:0]        r_mask;
    logic               r_ovld;
    t_out_item          r_oitem;

    t_tbl_wr     tbl_wr;
    t_amp_wr     amp_wr;
    t_sensor_rd  rd;
    logic [IDX_W-1:0] rd_addr;
    logic        in_acc;
    logic [31:0] norm_prod;
    logic [33:0] cut_cog_prod, cut_sel_prod;
    logic signed [34:0] px, py;
    logic signed [16:0] dx, dy;
    logic [34:0] d2;
    logic        div_start, divx_busy, divy_busy;
    logic [NUM_W-1:0] numx, numy, qx, qy;
    logic [SUM_W-1:0] magx, magy;
    logic [16:0] qxs, qys;
    logic [38:0] eprod;
    logic        pass_end;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_acc      = i_in_valid && (r_state == S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_ovld;
    assign o_out_item  = r_oitem;

    always_comb begin
        tbl_wr.we   = in_acc && !i_in_item.command;
        tbl_wr.addr = i_in_item.sensor_index;
        tbl_wr.x    = i_in_item.pos_x;
        tbl_wr.y    = i_in_item.pos_y;
        tbl_wr.gain = i_in_item.gain_recip;
        tbl_wr.en   = i_in_item.enabled;
        norm_prod   = 32'(r_amp) * 32'(rd.gain);
        amp_wr.we   = (r_state == S_SMP);
        amp_wr.addr = r_sidx;
        amp_wr.norm = norm_prod[14 +: NORM_W];
        amp_wr.sat  = r_sat;
        rd_addr     = (r_state == S_IDLE) ? i_in_item.sensor_index : r_cnt[IDX_W-1:0];
    end

    sacp_store u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tbl_wr  (tbl_wr),
        .i_amp_wr  (amp_wr),
        .i_rd_addr (rd_addr),
        .o_rd      (rd)
    );

    always_comb begin
        cut_cog_prod = 34'(r_peak) * 34'(r_cog_rel);
        cut_sel_prod = 34'(r_peak) * 34'(r_sel_rel);
        px = 35'(rd.x) * $signed({17'd0, rd.norm});
        py = 35'(rd.y) * $signed({17'd0, rd.norm});
        dx = 17'(r_gx) - 17'(rd.x);
        dy = 17'(r_gy) - 17'(rd.y);
        d2 = 35'(r_dx2) + 35'(r_dy2);
        magx = r_sx[SUM_W-1] ? SUM_W'(-r_sx) : SUM_W'(r_sx);
        magy = r_sy[SUM_W-1] ? SUM_W'(-r_sy) : SUM_W'(r_sy);
        numx = NUM_W'(magx) + NUM_W'(r_sw >> 1);
        numy = NUM_W'(magy) + NUM_W'(r_sw >> 1);
        div_start = (r_state == S_DIVST) && (r_sw != '0);
        qxs = r_sx[SUM_W-1] ? 17'(-qx[16:0]) : qx[16:0];
        qys = r_sy[SUM_W-1] ? 17'(-qy[16:0]) : qy[16:0];
        eprod = 39'(r_total) * 39'(r_escale);
        pass_end = (r_cnt == CNT_W'(SENSORS)) && !r_iss;
    end

    sacp_div u_divx (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (numx),
        .i_den   (r_sw),
        .o_busy  (divx_busy),
        .o_quo   (qx)
    );

    sacp_div u_divy (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (numy),
        .i_den   (r_sw),
        .o_busy  (divy_busy),
        .o_quo   (qy)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cog_abs <= '0;
            r_cog_rel <= '0;
            r_sel_abs <= '0;
            r_sel_rel <= '0;
            r_radius  <= 16'hFFFF;
            r_escale  <= 16'd256;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_COG_ABS: r_cog_abs <= i_cfg_data;
                CFG_COG_REL: r_cog_rel <= i_cfg_data[15:0];
                CFG_SEL_ABS: r_sel_abs <= i_cfg_data;
                CFG_SEL_REL: r_sel_rel <= i_cfg_data[15:0];
                CFG_RADIUS:  r_radius  <= i_cfg_data[15:0];
                CFG_ESCALE:  r_escale  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ovld  <= 1'b0;
            r_iss   <= 1'b0;
            r_s3v   <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (r_ovld && !i_out_stall && r_state != S_OUT) r_ovld <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc && i_in_item.command) begin
                        r_sidx  <= i_in_item.sensor_index;
                        r_amp   <= i_in_item.amplitude;
                        r_sat   <= i_in_item.saturated;
                        r_last  <= i_in_item.last;
                        r_state <= S_SMP;
                    end
                end
                S_SMP: begin
                    r_cnt   <= '0;
                    r_iss   <= 1'b0;
                    r_peak  <= '0;
                    r_total <= '0;
                    r_state <= r_last ? S_P1 : S_IDLE;
                end
                S_P1, S_P2, S_P3: begin
                    r_iss     <= (r_cnt != CNT_W'(SENSORS));
                    r_iss_idx <= r_cnt[IDX_W-1:0];
                    if (r_cnt != CNT_W'(SENSORS)) r_cnt <= r_cnt + 1'b1;
                    if (r_state == S_P1) begin
                        if (r_iss) begin
                            if (rd.norm > r_peak) r_peak <= rd.norm;
                            r_total <= r_total + TOT_W'(rd.norm);
                        end
                        if (pass_end) r_state <= S_CUT;
                    end else if (r_state == S_P2) begin
                        if (r_iss && rd.norm >= r_cut_cog) begin
                            r_sx <= r_sx + SUM_W'(px);
                            r_sy <= r_sy + SUM_W'(py);
                            r_sw <= r_sw + TOT_W'(rd.norm);
                        end
                        if (pass_end) r_state <= S_DIVST;
                    end else begin
                        r_s3v   <= r_iss;
                        r_s3idx <= r_iss_idx;
                        r_s3ok  <= rd.en && !rd.sat && (rd.norm > r_cut_sel);
                        r_dx2   <= 34'(dx) * 34'(dx);
                        r_dy2   <= 34'(dy) * 34'(dy);
                        if (r_s3v && r_s3ok &&
                            d2 <= 35'(32'(r_radius) * 32'(r_radius))) begin
                            r_count <= r_count + 1'b1;
                            r_mask[r_s3idx] <= 1'b1;
                        end
                        if (pass_end && !r_s3v) r_state <= S_OUT;
                    end
                end
                S_CUT: begin
                    r_cut_cog <= (cut_cog_prod[33:16] > r_cog_abs) ?
                                 cut_cog_prod[33:16] : r_cog_abs;
                    r_cut_sel <= (cut_sel_prod[33:16] > r_sel_abs) ?
                                 cut_sel_prod[33:16] : r_sel_abs;
                    r_sx    <= '0;
                    r_sy    <= '0;
                    r_sw    <= '0;
                    r_cnt   <= '0;
                    r_iss   <= 1'b0;
                    r_state <= S_P2;
                end
                S_DIVST: begin
                    r_weight <= (r_sw != '0);
                    r_gx     <= '0;
                    r_gy     <= '0;
                    r_count  <= '0;
                    r_mask   <= '0;
                    r_cnt    <= '0;
                    r_iss    <= 1'b0;
                    r_s3v    <= 1'b0;
                    r_state  <= (r_sw != '0) ? S_DIV : S_OUT;
                end
                S_DIV: begin
                    if (!divx_busy && !divy_busy) begin
                        r_gx    <= qxs[15:0];
                        r_gy    <= qys[15:0];
                        r_state <= S_P3;
                    end
                end
                S_OUT: begin
                    if (!r_ovld || !i_out_stall) begin
                        r_ovld <= 1'b1;
                        r_oitem.status <= !r_weight ? ST_NOWEIGHT :
                            ((r_count < 6'(MIN_ACTIVE)) ? ST_FEW : ST_OK);
                        r_oitem.guess_x      <= r_gx;
                        r_oitem.guess_y      <= r_gy;
                        r_oitem.energy       <= 32'(eprod[38:8]);
                        r_oitem.active_count <= r_count;
                        r_oitem.active_mask  <= r_mask;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

@@ src/sacp_store.sv @@
`default_nettype none
module sacp_store (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire sacp_pkg::t_tbl_wr         i_tbl_wr,
    input  wire sacp_pkg::t_amp_wr         i_amp_wr,
    input  wire logic [sacp_pkg::IDX_W-1:0] i_rd_addr,
    output sacp_pkg::t_sensor_rd           o_rd
);
    import sacp_pkg::*;

    logic signed [15:0] r_mem_x    [SENSORS];
    logic signed [15:0] r_mem_y    [SENSORS];
    logic [15:0]        r_mem_gain [SENSORS];
    logic               r_mem_en   [SENSORS];
    logic [NORM_W-1:0]  r_mem_norm [SENSORS];
    logic               r_mem_sat  [SENSORS];
    logic [SENSORS-1:0] r_tbl_vld;
    logic [SENSORS-1:0] r_amp_vld;

    logic signed [15:0] r_q_x, r_q_y;
    logic [15:0]        r_q_gain;
    logic               r_q_en;
    logic [NORM_W-1:0]  r_q_norm;
    logic               r_q_sat;
    logic               r_q_tv, r_q_av;

    always_ff @(posedge i_clk) begin
        if (i_tbl_wr.we) begin
            r_mem_x[i_tbl_wr.addr]    <= i_tbl_wr.x;
            r_mem_y[i_tbl_wr.addr]    <= i_tbl_wr.y;
            r_mem_gain[i_tbl_wr.addr] <= i_tbl_wr.gain;
            r_mem_en[i_tbl_wr.addr]   <= i_tbl_wr.en;
        end
        if (i_amp_wr.we) begin
            r_mem_norm[i_amp_wr.addr] <= i_amp_wr.norm;
            r_mem_sat[i_amp_wr.addr]  <= i_amp_wr.sat;
        end
        r_q_x    <= r_mem_x[i_rd_addr];
        r_q_y    <= r_mem_y[i_rd_addr];
        r_q_gain <= r_mem_gain[i_rd_addr];
        r_q_en   <= r_mem_en[i_rd_addr];
        r_q_norm <= r_mem_norm[i_rd_addr];
        r_q_sat  <= r_mem_sat[i_rd_addr];
        r_q_tv   <= r_tbl_vld[i_rd_addr];
        r_q_av   <= r_amp_vld[i_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tbl_vld <= '0;
            r_amp_vld <= '0;
        end else begin
            if (i_tbl_wr.we) r_tbl_vld[i_tbl_wr.addr] <= 1'b1;
            if (i_amp_wr.we) r_amp_vld[i_amp_wr.addr] <= 1'b1;
        end
    end

    always_comb begin
        o_rd.x    = r_q_x;
        o_rd.y    = r_q_y;
        o_rd.gain = r_q_tv ? r_q_gain : UNITY_GAIN;
        o_rd.en   = r_q_tv ? r_q_en : 1'b1;
        o_rd.norm = r_q_norm;
        o_rd.sat  = r_q_av ? r_q_sat : 1'b0;
    end

endmodule
`default_nettype wire

@@ src/sacp_div.sv @@
`default_nettype none
module sacp_div (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_start,
    input  wire logic [sacp_pkg::NUM_W-1:0] i_num,
    input  wire logic [sacp_pkg::TOT_W-1:0] i_den,
    output logic                            o_busy,
    output logic [sacp_pkg::NUM_W-1:0]      o_quo
);
    import sacp_pkg::*;

    localparam int DCNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0]  r_num;
    logic [TOT_W-1:0]  r_den;
    logic [TOT_W-1:0]  r_rem;
    logic [DCNT_W-1:0] r_cnt;
    logic              r_busy;
    logic [TOT_W:0]    trial;
    logic              qbit;

    always_comb begin
        trial = {r_rem, r_num[NUM_W-1]};
        qbit  = (trial >= {1'b0, r_den});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= DCNT_W'(NUM_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == DCNT_W'(1)) r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_rem <= qbit ? TOT_W'(trial - {1'b0, r_den}) : trial[TOT_W-1:0];
            r_num <= {r_num[NUM_W-2:0], qbit};
        end
    end

    assign o_busy = r_busy;
    assign o_quo  = r_num;

endmodule
`default_nettype wire

@@ tb/sensor_array_centroid_prefit_chk.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sensor_array_centroid_prefit_chk
    import sacp_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    input  wire logic      i_in_stall,
    input  wire t_in_item  i_in_item,
    input  wire logic      i_out_valid,
    input  wire logic      i_out_stall,
    input  wire t_out_item i_out_item,
    input  wire logic      i_cfg_valid,
    input  wire logic      i_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [17:0] i_cfg_data,
    output int             o_errors,
    output int             o_pending,
    output int             o_events
);

    logic [17:0] cog_abs, sel_abs;
    logic [15:0] cog_rel, sel_rel, radius, escale;
    logic signed [15:0] pos_x [SENSORS];
    logic signed [15:0] pos_y [SENSORS];
    logic [15:0] gain [SENSORS];
    logic        en   [SENSORS];
    logic [17:0] amp  [SENSORS];
    logic        sat  [SENSORS];
    t_out_item   expected_events [$];

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    function automatic longint round_div(input longint num, input longint den);
        longint mag;
        mag = num < 0 ? -num : num;
        mag = (mag + den / 2) / den;
        return num < 0 ? -mag : mag;
    endfunction

    function automatic t_out_item locate_event();
        t_out_item r;
        longint peak, total, cut, sx, sy, sw, gx, gy, dx, dy, e, r2;
        int count;
        peak = amp[0];
        total = 0;
        sx = 0; sy = 0; sw = 0; gx = 0; gy = 0; count = 0;
        r = '0;
        for (int i = 0; i < SENSORS; i++) begin
            if (amp[i] > peak) peak = amp[i];
            total += amp[i];
        end
        cut = (peak * cog_rel) >>> 16;
        if (cog_abs > cut) cut = cog_abs;
        for (int i = 0; i < SENSORS; i++) begin
            if (amp[i] >= cut) begin
                sx += longint'(pos_x[i]) * amp[i];
                sy += longint'(pos_y[i]) * amp[i];
                sw += amp[i];
            end
        end
        if (sw > 0) begin
            gx = round_div(sx, sw);
            gy = round_div(sy, sw);
        end
        e = (total * escale) >>> 8;
        if (e > 64'hFFFF_FFFF) e = 64'hFFFF_FFFF;
        cut = (peak * sel_rel) >>> 16;
        if (sel_abs > cut) cut = sel_abs;
        r2 = longint'(radius) * radius;
        if (sw > 0) begin
            for (int i = 0; i < SENSORS; i++) begin
                dx = gx - pos_x[i];
                dy = gy - pos_y[i];
                if (en[i] && !sat[i] && amp[i] > cut && dx * dx + dy * dy <= r2) begin
                    count++;
                    r.active_mask[i] = 1'b1;
                end
            end
        end
        r.status = sw == 0 ? ST_NOWEIGHT : (count < MIN_ACTIVE ? ST_FEW : ST_OK);
        r.guess_x = gx[15:0];
        r.guess_y = gy[15:0];
        r.energy = e[31:0];
        r.active_count = 6'(count);
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            cog_abs <= '0; cog_rel <= '0; sel_abs <= '0; sel_rel <= '0;
            radius <= 16'hFFFF; escale <= 16'd256;
            for (int i = 0; i < SENSORS; i++) begin
                gain[i] = UNITY_GAIN; en[i] = 1'b1; sat[i] = 1'b0;
                pos_x[i] = '0; pos_y[i] = '0; amp[i] = '0;
            end
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_COG_ABS: cog_abs <= i_cfg_data;
                    CFG_COG_REL: cog_rel <= i_cfg_data[15:0];
                    CFG_SEL_ABS: sel_abs <= i_cfg_data;
                    CFG_SEL_REL: sel_rel <= i_cfg_data[15:0];
                    CFG_RADIUS:  radius <= i_cfg_data[15:0];
                    CFG_ESCALE:  escale <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) begin
                if (!i_in_item.command) begin
                    pos_x[i_in_item.sensor_index] = i_in_item.pos_x;
                    pos_y[i_in_item.sensor_index] = i_in_item.pos_y;
                    gain[i_in_item.sensor_index] = i_in_item.gain_recip;
                    en[i_in_item.sensor_index] = i_in_item.enabled;
                end else begin
                    amp[i_in_item.sensor_index] =
                        18'((32'(i_in_item.amplitude) * gain[i_in_item.sensor_index]) >> 14);
                    sat[i_in_item.sensor_index] = i_in_item.saturated;
                    if (i_in_item.last) expected_events.push_back(locate_event());
                end
            end
            if (i_out_valid && !i_out_stall) begin
                o_events++;
                if (expected_events.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = expected_events.pop_front();
                    if (i_out_item.status !== want.status)
                        report_mismatch("status", i_out_item.status, want.status);
                    if (i_out_item.guess_x !== want.guess_x)
                        report_mismatch("guess_x", i_out_item.guess_x, want.guess_x);
                    if (i_out_item.guess_y !== want.guess_y)
                        report_mismatch("guess_y", i_out_item.guess_y, want.guess_y);
                    if (i_out_item.energy !== want.energy)
                        report_mismatch("energy", i_out_item.energy, want.energy);
                    if (i_out_item.active_count !== want.active_count)
                        report_mismatch("active_count", i_out_item.active_count,
                                        want.active_count);
                    if (i_out_item.active_mask !== want.active_mask)
                        report_mismatch("active_mask", i_out_item.active_mask,
                                        want.active_mask);
                end
            end
        end
        o_pending <= expected_events.size();
    end

    initial begin
        o_errors = 0;
        o_events = 0;
        o_pending = 0;
    end

endmodule
`default_nettype wire

@@ tb/sensor_array_centroid_prefit_tb.sv @@
`timescale 1ns / 1ps
`default_nettype none
module sensor_array_centroid_prefit_tb;
    import sacp_pkg::*;

    localparam int WATCHDOG = 20000;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    t_in_item    in_item = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    t_out_item   out_item;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [17:0] cfg_data = '0;
    int          errors, pending, events;
    int          idle_pct = 26;
    int          hold_off = 0;
    int          quiet = 0;
    int          samples_sent = 0;

    always #4 i_clk = ~i_clk;

    sensor_array_centroid_prefit uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall), .i_in_item(in_item),
        .o_out_valid(out_valid), .i_out_stall(out_stall), .o_out_item(out_item),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    sensor_array_centroid_prefit_chk chk (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(in_valid), .i_in_stall(in_stall), .i_in_item(in_item),
        .i_out_valid(out_valid), .i_out_stall(out_stall), .i_out_item(out_item),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending), .o_events(events)
    );

    // receiver: random stall, or a long counted hold-off
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= $urandom_range(99) < idle_pct;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
            (cfg_valid && cfg_ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= WATCHDOG) begin
            $display("watchdog expired, %0d results pending", pending);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // valid stays high after the item is taken; the next call may drop it or send a new item, wait_idle drops it
    task automatic send_item(input t_in_item it);
        while ($urandom_range(99) < idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_item <= it;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        if (it.command) samples_sent++;
    endtask

    task automatic load_sensor(input int idx, input int x, input int y, input int g,
                               input bit e);
        t_in_item it;
        it = '0;
        it.sensor_index = 5'(idx);
        it.pos_x = 16'(x);
        it.pos_y = 16'(y);
        it.gain_recip = 16'(g);
        it.enabled = e;
        it.amplitude = 16'($urandom);
        it.saturated = 1'($urandom);
        it.last = 1'($urandom);
        send_item(it);
    endtask

    task automatic send_sample(input int idx, input int a, input bit s, input bit l);
        t_in_item it;
        logic [95:0] noise;
        noise = {$urandom, $urandom, $urandom};
        it = noise[$bits(t_in_item)-1:0];
        it.command = 1'b1;
        it.sensor_index = 5'(idx);
        it.amplitude = 16'(a);
        it.saturated = s;
        it.last = l;
        send_item(it);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (150) @(posedge i_clk);
    endtask

    // valid stays high across back-to-back writes; the caller drops it
    task automatic write_reg(input logic [2:0] idx, input logic [17:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
    endtask

    task automatic random_event(input int amp_max);
        int n;
        n = $urandom_range(40, 8);
        for (int k = 0; k < n; k++)
            send_sample($urandom_range(31), $urandom_range(amp_max),
                        $urandom_range(9) == 0, k == n - 1);
    endtask

    task automatic random_table();
        for (int i = 0; i < SENSORS; i++)
            load_sensor(i, $urandom_range(4000) - 2000, $urandom_range(4000) - 2000,
                        $urandom_range(9) == 0 ? $urandom_range(65535)
                                               : $urandom_range(20000, 12000),
                        $urandom_range(7) != 0);
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extreme positions and gains, every sensor written
        for (int i = 0; i < SENSORS; i++)
            load_sensor(i, (i % 2) ? 32767 : -32768, (i % 3) ? -32768 : 32767,
                        (i == 5) ? 65535 : UNITY_GAIN, 1'b1);
        for (int i = 0; i < SENSORS; i++)
            send_sample(i, 0, 1'b0, i == SENSORS - 1);   // no weight
        send_sample(3, 65535, 1'b0, 1'b1);              // few active
        send_sample(5, 65535, 1'b1, 1'b0);
        send_sample(7, 65535, 1'b0, 1'b0);              // ties sensor 3, below the peak
        send_sample(9, 1, 1'b0, 1'b1);
        load_sensor(31, 100, -100, 0, 1'b0);
        send_sample(31, 65535, 1'b0, 1'b1);             // zero gain sensor
        wait_idle();

        write_reg(CFG_COG_ABS, 18'h3FFFF);
        write_reg(CFG_COG_REL, 18'hFFFF);
        write_reg(CFG_SEL_ABS, 18'h3FFFF);
        write_reg(CFG_SEL_REL, 18'hFFFF);
        write_reg(CFG_RADIUS, 18'd0);
        write_reg(CFG_ESCALE, 18'hFFFF);
        cfg_valid <= 1'b0;
        send_sample(0, 65535, 1'b0, 1'b1);
        send_sample(5, 65535, 1'b0, 1'b1);
        wait_idle();

        for (int phase = 0; phase < 6; phase++) begin
            write_reg(CFG_COG_ABS, phase == 5 ? 18'h3FFFF : 18'($urandom_range(3000)));
            write_reg(CFG_COG_REL, 18'($urandom_range(40000)));
            write_reg(CFG_SEL_ABS, phase == 0 ? 18'd0 : 18'($urandom_range(3000)));
            write_reg(CFG_SEL_REL, 18'($urandom_range(30000)));
            write_reg(CFG_RADIUS, phase == 1 ? 18'hFFFF : 18'($urandom_range(4000, 200)));
            write_reg(CFG_ESCALE, phase == 2 ? 18'h0 : 18'($urandom_range(65535)));
            cfg_valid <= 1'b0;
            idle_pct = (phase == 3) ? 0 : 26;
            random_table();
            if (phase == 4) hold_off = 600;
            for (int ev = 0; ev < 6; ev++)
                random_event(ev % 3 == 0 ? 65535 : 8000);
            wait_idle();
        end

        wait_idle();
        $display("covered %0d samples and %0d events over 8 register settings",
                 samples_sent, events);
        $display("including no-weight, few-active, saturation and long stall cases");
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
`default_nettype wire

@@ sim.f @@
src/sacp_pkg.sv
src/sacp_store.sv
src/sacp_div.sv
src/sensor_array_centroid_prefit.sv
tb/sensor_array_centroid_prefit_chk.sv
tb/sensor_array_centroid_prefit_tb.sv
